// File: rtl/core/ordered_list_table_macros.svh
// Assertion macros for the ordered list table checker.
`ifndef ORDERED_LIST_TABLE_MACROS_SVH
`define ORDERED_LIST_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define OLT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: rtl/core/olt_pkg.sv
// Types and codes shared by the ordered list table modules.
package olt_pkg;

    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int CNT_O_W = 7;

    typedef logic [2:0] t_cmd;
    typedef logic [1:0] t_status;

    localparam t_cmd CMD_APPEND = 3'd0;
    localparam t_cmd CMD_SEARCH = 3'd1;
    localparam t_cmd CMD_DELETE = 3'd2;
    localparam t_cmd CMD_READ   = 3'd3;
    localparam t_cmd CMD_WRITE  = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_OOB       = 2'd3;

    typedef struct packed {
        t_status                   status;
        logic signed [VAL_W-1:0]   read_data;
        logic [CNT_O_W-1:0]        entry_count;
    } t_res;

endpackage

// File: rtl/core/olt_if.sv
// Command and result channel interfaces for the ordered list table.
interface olt_in_if;
    import olt_pkg::*;
    logic                    valid;
    logic                    ready;
    t_cmd                    cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, cmd, value, position, input ready);
    modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface olt_out_if;
    import olt_pkg::*;
    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic signed [VAL_W-1:0] read_data;
    logic [CNT_O_W-1:0]      entry_count;

    modport source (output valid, status, read_data, entry_count, input ready);
    modport sink   (input valid, status, read_data, entry_count, output ready);
endinterface

// File: rtl/core/ordered_list_table.sv
// Ordered list table top level: sequencer, entry store and result register.
// Usage:
//   i_in carries one command word (cmd, value, position); it is taken when
//   valid and ready are both high. o_out returns exactly one result word
//   (status, read_data, entry_count) per command, in command order.
// Append, write, out-of-range read or write and unused codes finish in the
// execute state; an in-range read adds a wait state for the registered read
// data. A search scans from entry 0 and stops at the first match; a delete
// scans every entry through the single read port of the entry store.
// One command is in the sequencer at a time; the next is taken once the
// previous result has moved into the output register.
// Reset clears the entry count and the control state; entry contents are
// not cleared and need no clearing pass.
// When the receiver stalls, the result holds in the output register and a
// further command may still run; its result waits until the register frees.
module ordered_list_table #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    olt_in_if.sink    i_in,
    olt_out_if.source o_out
);
    import olt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                    res_vld;
    logic                    res_rdy;
    t_res                    res;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic signed [VAL_W-1:0] wdata;
    logic [AW-1:0]           raddr;
    logic signed [VAL_W-1:0] rdata;

    logic r_out_vld;
    t_res r_out;

    olt_seq #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .CW   (CW)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_res_vld(res_vld),
        .i_res_rdy(res_rdy),
        .o_res    (res),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .i_rdata  (rdata)
    );

    olt_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign res_rdy = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_rdy) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_rdy && res_vld) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_out.status;
    assign o_out.read_data   = r_out.read_data;
    assign o_out.entry_count = r_out.entry_count;

endmodule

// File: rtl/core/olt_mem.sv
// Entry store: one write port, one read port, registered read data.
module olt_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic signed [olt_pkg::VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic signed [olt_pkg::VAL_W-1:0] o_rdata
);
    import olt_pkg::*;

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/olt_seq.sv
// Command sequencer: decodes a word, scans and compacts the entry store.
module olt_seq #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    olt_in_if.sink                           i_in,
    output logic                             o_res_vld,
    input  logic                             i_res_rdy,
    output olt_pkg::t_res                    o_res,
    output logic                             o_we,
    output logic [AW-1:0]                    o_waddr,
    output logic signed [olt_pkg::VAL_W-1:0] o_wdata,
    output logic [AW-1:0]                    o_raddr,
    input  logic signed [olt_pkg::VAL_W-1:0] i_rdata
);
    import olt_pkg::*;

    localparam int LW = (CW > POS_W) ? CW : POS_W;
    localparam int OW = (CW > CNT_O_W) ? CW : CNT_O_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RDWT = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]              r_state, n_state;
    t_cmd                    r_cmd;
    logic signed [VAL_W-1:0] r_val;
    logic [POS_W-1:0]        r_pos;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_idx, n_idx;
    logic                    r_found, n_found;
    t_status                 r_status, n_status;
    logic signed [VAL_W-1:0] r_rdata, n_rdata;

    logic [LW-1:0] pos_ext;
    logic [LW-1:0] cnt_ext;
    logic          oob;
    logic          full;
    logic          hit;
    logic          last;
    logic [OW-1:0] cnt_out;

    assign pos_ext = LW'(r_pos);
    assign cnt_ext = LW'(r_count);
    assign oob     = pos_ext >= cnt_ext;
    assign full    = r_count >= CW'(DEPTH);
    assign hit     = !r_found && (i_rdata == r_val);
    assign last    = (CW'(r_idx) + CW'(1)) >= r_count;
    assign cnt_out = OW'(r_count);

    assign i_in.ready = (r_state == S_IDLE);
    assign o_res_vld  = (r_state == S_RESP);
    assign o_res.status      = r_status;
    assign o_res.read_data   = r_rdata;
    assign o_res.entry_count = cnt_out[CNT_O_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_found  = r_found;
        n_status = r_status;
        n_rdata  = r_rdata;
        o_we     = 1'b0;
        o_waddr  = r_count[AW-1:0];
        o_wdata  = r_val;
        o_raddr  = pos_ext[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state  = S_EXEC;
                    n_status = ST_OK;
                    n_rdata  = '0;
                    n_idx    = '0;
                    n_found  = 1'b0;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (r_cmd)
                    CMD_APPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_we    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_WRITE: begin
                        if (oob) begin
                            n_status = ST_OOB;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = pos_ext[AW-1:0];
                        end
                    end
                    CMD_READ: begin
                        if (oob) begin
                            n_status = ST_OOB;
                        end else begin
                            n_state = S_RDWT;
                        end
                    end
                    CMD_SEARCH, CMD_DELETE: begin
                        o_raddr = '0;
                        if (r_count == '0) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDWT: begin
                n_rdata = i_rdata;
                n_state = S_RESP;
            end
            S_SCAN: begin
                // i_rdata holds entry r_idx; after a delete match, each entry
                // moves down one place as it streams by
                o_raddr = r_idx + AW'(1);
                if (r_found) begin
                    o_we    = 1'b1;
                    o_waddr = r_idx - AW'(1);
                    o_wdata = i_rdata;
                end
                if (r_cmd == CMD_SEARCH && hit) begin
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end else if (last) begin
                    n_state = S_RESP;
                    if (r_cmd == CMD_DELETE && (r_found || hit)) begin
                        n_status = ST_OK;
                        n_count  = r_count - CW'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_found = r_found || hit;
                end
            end
            S_RESP: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_cmd <= i_in.cmd;
            r_val <= i_in.value;
            r_pos <= i_in.position;
        end
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_status <= n_status;
        r_rdata  <= n_rdata;
    end

endmodule

// File: rtl/core/olt_chk.sv
// Port-level checks for the ordered list table, bound to the top level.
`include "ordered_list_table_macros.svh"

module olt_chk #(
    parameter int DEPTH = 64
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input olt_pkg::t_status                 i_status,
    input logic signed [olt_pkg::VAL_W-1:0] i_read_data,
    input logic [olt_pkg::CNT_O_W-1:0]      i_entry_count
);
    import olt_pkg::*;

    localparam logic [CNT_O_W-1:0] FULL_CNT = CNT_O_W'(DEPTH);

    `OLT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_read_data) && $stable(i_entry_count))
    `OLT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `OLT_ASSERT_NOW(a_data_only_ok, i_clk, i_rst_n, i_out_valid && (i_read_data != '0), i_status == ST_OK)
    `OLT_ASSERT_NOW(a_full_count, i_clk, i_rst_n, i_out_valid && (i_status == ST_FULL), i_entry_count == FULL_CNT)

endmodule

bind ordered_list_table olt_chk #(
    .DEPTH(DEPTH)
) u_olt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_read_data  (o_out.read_data),
    .i_entry_count(o_out.entry_count)
);

// File: tb/tb_top.sv
// Self-checking testbench for the ordered list table: directed and random command streams.
module tb_top;
    import olt_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 680;
    localparam int CALM_ITEMS   = 100;   // final stretch without bursts
    localparam int DRAIN_CYCLES = 150;   // idle margin after the last result
    localparam int CYCLE_LIMIT  = 600000;

    localparam t_cmd CMD_LAST_UNUSED = 3'd7;

    typedef struct {
        t_cmd                    cmd;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_cmd_word;

    logic clk;
    logic rst_n;

    olt_in_if  in_ch ();
    olt_out_if out_ch ();

    ordered_list_table #(.DEPTH(DEPTH)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_cmd_word               cmd_q[$];
    t_res                    due_results[$];
    logic signed [VAL_W-1:0] list_vals[$];   // predicted contents, in order

    int  err_cnt;
    int  cycles;
    bit  calm_tail;
    int  src_gap;
    int  snk_stall;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Expected result of one command; also advances the predicted list.
    function automatic t_res run_command(t_cmd_word w);
        t_res r;
        int   hit;
        r.status    = ST_OK;
        r.read_data = '0;
        hit         = -1;
        case (w.cmd)
            CMD_APPEND: begin
                if (list_vals.size() >= DEPTH) r.status = ST_FULL;
                else list_vals.push_back(w.value);
            end
            CMD_SEARCH, CMD_DELETE: begin
                for (int i = list_vals.size() - 1; i >= 0; i--)
                    if (list_vals[i] == w.value) hit = i;
                if (hit < 0) r.status = ST_NOT_FOUND;
                else if (w.cmd == CMD_DELETE) list_vals.delete(hit);
            end
            CMD_READ: begin
                if (w.position >= list_vals.size()) r.status = ST_OOB;
                else r.read_data = list_vals[w.position];
            end
            CMD_WRITE: begin
                if (w.position >= list_vals.size()) r.status = ST_OOB;
                else list_vals[w.position] = w.value;
            end
            default: ;
        endcase
        r.entry_count = CNT_O_W'(list_vals.size());
        return r;
    endfunction

    task automatic queue_cmd(t_cmd c, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
        t_cmd_word w;
        w.cmd      = c;
        w.value    = v;
        w.position = p;
        cmd_q.push_back(w);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return VAL_W'($signed($urandom_range(0, 4)) - 2);   // dense duplicates
        if (roll < 30) return {1'b1, {(VAL_W-1){1'b0}}};
        if (roll < 35) return {1'b0, {(VAL_W-1){1'b1}}};
        return $urandom();
    endfunction

    // Mostly a key that is present, so searches hit and deletes shift.
    function automatic logic signed [VAL_W-1:0] pick_key();
        if (list_vals.size() > 0 && $urandom_range(0, 99) < 70)
            return list_vals[$urandom_range(0, list_vals.size() - 1)];
        return pick_value();
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if (list_vals.size() > 0 && $urandom_range(0, 99) < 75)
            return POS_W'($urandom_range(0, list_vals.size() - 1));
        return POS_W'($urandom_range(0, DEPTH - 1));
    endfunction

    // Command source: one word per handshake, random idle bursts.
    always @(posedge clk) begin
        t_cmd_word w;
        if (!rst_n) begin
            in_ch.valid    <= 1'b0;
            in_ch.cmd      <= CMD_APPEND;
            in_ch.value    <= '0;
            in_ch.position <= '0;
            src_gap        = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                w.cmd      = in_ch.cmd;
                w.value    = in_ch.value;
                w.position = in_ch.position;
                due_results.push_back(run_command(w));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end else if (cmd_q.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
                    src_gap = $urandom_range(1, 14) - 1;
                    in_ch.valid <= 1'b0;
                end else begin
                    w = cmd_q.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.cmd      <= w.cmd;
                    in_ch.value    <= w.value;
                    in_ch.position <= w.position;
                end
            end
        end
    end

    // Result sink: checks each word against the oldest prediction.
    always @(posedge clk) begin
        t_res exp_r;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            snk_stall    = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (due_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result word with no command outstanding", $time);
                end else begin
                    exp_r = due_results.pop_front();
                    if (out_ch.status !== exp_r.status || out_ch.read_data !== exp_r.read_data
                            || out_ch.entry_count !== exp_r.entry_count) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: mismatch exp status %0d data %0d count %0d, got %0d %0d %0d",
                                $time, exp_r.status, exp_r.read_data, exp_r.entry_count,
                                out_ch.status, out_ch.read_data, out_ch.entry_count);
                    end
                end
            end
            if (snk_stall > 0) begin
                snk_stall--;
                out_ch.ready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
                snk_stall = $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int   phase;
        int   phase_left;
        int   roll;
        t_cmd c;
        calm_tail      = 1'b0;
        phase          = 0;
        phase_left     = 0;
        rst_n          = 1'b0;

        // Empty store, unused codes, extremes, duplicate keys, gap closing.
        queue_cmd(CMD_SEARCH, 5, 0);
        queue_cmd(CMD_DELETE, 5, 0);
        queue_cmd(CMD_READ, 0, 0);
        queue_cmd(CMD_WRITE, 7, 0);
        for (int k = CMD_WRITE + 1; k <= CMD_LAST_UNUSED; k++)
            queue_cmd(t_cmd'(k), $urandom(), POS_W'($urandom()));
        queue_cmd(CMD_APPEND, {1'b1, {(VAL_W-1){1'b0}}}, 0);
        queue_cmd(CMD_APPEND, {1'b0, {(VAL_W-1){1'b1}}}, 0);
        queue_cmd(CMD_APPEND, 0, 0);
        queue_cmd(CMD_APPEND, -1, 0);
        queue_cmd(CMD_APPEND, {1'b0, {(VAL_W-1){1'b1}}}, 0);
        queue_cmd(CMD_SEARCH, {1'b0, {(VAL_W-1){1'b1}}}, 0);
        queue_cmd(CMD_SEARCH, 1, 0);
        queue_cmd(CMD_READ, 0, 4);
        queue_cmd(CMD_READ, 0, 5);
        queue_cmd(CMD_READ, 0, POS_W'(DEPTH - 1));
        queue_cmd(CMD_WRITE, 32'h5555_aaaa, 0);
        queue_cmd(CMD_READ, 0, 0);
        queue_cmd(CMD_DELETE, {1'b0, {(VAL_W-1){1'b1}}}, 0);
        queue_cmd(CMD_READ, 0, 1);
        queue_cmd(CMD_READ, 0, 3);
        queue_cmd(CMD_DELETE, 12345, 0);
        queue_cmd(CMD_WRITE, -1, POS_W'(DEPTH - 1));
        queue_cmd(CMD_SEARCH, {1'b1, {(VAL_W-1){1'b0}}}, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Phases: fill toward full, drain by deletes, or a mix.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            while (cmd_q.size() >= 2) @(negedge clk);
            if (phase_left == 0) begin
                phase      = $urandom_range(0, 2);
                phase_left = (phase == 0) ? $urandom_range(60, 110) : $urandom_range(30, 80);
            end
            phase_left--;
            if (n >= RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                c = t_cmd'($urandom_range(CMD_WRITE + 1, CMD_LAST_UNUSED));
            else if (phase == 0)
                c = (roll < 77) ? CMD_APPEND : (roll < 85) ? CMD_SEARCH :
                    (roll < 93) ? CMD_READ : CMD_WRITE;
            else if (phase == 1)
                c = (roll < 62) ? CMD_DELETE : (roll < 74) ? CMD_SEARCH :
                    (roll < 86) ? CMD_READ : (roll < 94) ? CMD_WRITE : CMD_APPEND;
            else
                c = (roll < 32) ? CMD_APPEND : (roll < 57) ? CMD_DELETE :
                    (roll < 72) ? CMD_SEARCH : (roll < 87) ? CMD_READ : CMD_WRITE;
            if (c == CMD_SEARCH || c == CMD_DELETE)
                queue_cmd(c, pick_key(), POS_W'($urandom()));
            else
                queue_cmd(c, pick_value(), pick_pos());
        end

        while (cmd_q.size() != 0 || in_ch.valid || due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_cnt == 0 && due_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
